// File: sv/landmark_lower_bound_engine_defines.svh
// Assertion macros shared by the landmark lower bound engine RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LANDMARK_LOWER_BOUND_ENGINE_DEFINES_SVH
`define LANDMARK_LOWER_BOUND_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LLB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LLB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/llb_pkg.sv
// Types and codes of the landmark lower bound engine.
// No dependencies; imported by the engine modules.
package llb_pkg;

    localparam logic [1:0] OP_WR_FWD   = 2'd0;
    localparam logic [1:0] OP_WR_REV   = 2'd1;
    localparam logic [1:0] OP_BOUND    = 2'd2;
    localparam logic [1:0] OP_FARTHEST = 2'd3;

    localparam logic RK_BOUND = 1'b0;
    localparam logic RK_FAR   = 1'b1;

    localparam logic CFG_LANDMARK_COUNT = 1'b0;
    localparam logic CFG_NODE_COUNT     = 1'b1;

    localparam logic UNIT_MAX_DIFF = 1'b0;
    localparam logic UNIT_MIN      = 1'b1;

    localparam int LMC_W  = 5;
    localparam int NDC_W  = 11;
    localparam int CFG_W  = 11;
    localparam int NODE_W = 10;
    localparam int VAL_W  = 32;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [3:0]        landmark_index;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [VAL_W-1:0]  distance;
    } t_in_item;

    typedef struct packed {
        logic              result_kind;
        logic [VAL_W-1:0]  bound;
        logic [NODE_W-1:0] farthest_node;
        logic [VAL_W-1:0]  coverage_score;
    } t_out_item;

    typedef struct packed {
        logic mode;
        logic first;
    } t_unit_ctl;

endpackage

// File: sv/landmark_lower_bound_engine.sv
// Landmark lower bound engine top level: sequencer, distance tables, result register.
// Depends on llb_pkg, llb_ram, llb_unit and landmark_lower_bound_engine_defines.svh.
//
// A table write is taken while idle and the input is ready again at once. A lower
// bound query first subtracts MAX_NODES from a node field until it is below
// MAX_NODES, then reads every landmark; a farthest query reads every landmark for
// each node, and with no landmarks or nodes goes straight to the result.
// Time is set by the one read per landmark and node that each table port gives
// per cycle, feeding one shared compare/subtract unit. One query is in work at a
// time; the input stalls until its result is in the output register, which holds
// while the next item is taken. Table contents are undefined after reset and
// there is no clearing pass.
`include "landmark_lower_bound_engine_defines.svh"

module landmark_lower_bound_engine import llb_pkg::*; #(
    parameter int MAX_LANDMARKS = 16,
    parameter int MAX_NODES     = 1024,
    parameter int DIST_WIDTH    = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int DW    = DIST_WIDTH;
    localparam int DEPTH = MAX_LANDMARKS * MAX_NODES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(MAX_LANDMARKS + 1);
    localparam int CW    = $clog2(MAX_NODES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WRAP  = 2'd1;
    localparam logic [1:0] S_ISSUE = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [LMC_W-1:0] r_lm_count;
    logic [NDC_W-1:0] r_node_count;

    logic             r_kind;
    logic [NODE_W-1:0] r_u;
    logic [NODE_W-1:0] r_v;
    logic [LW-1:0]    r_lm;
    logic [CW-1:0]    r_node;
    logic [AW-1:0]    r_base;

    logic             r_p_valid;
    logic             r_p_first;
    logic             r_p_last;
    logic [CW-1:0]    r_p_node;
    logic [DW-1:0]    r_acc;

    logic             r_fin_valid;
    logic [DW-1:0]    r_fin_m;
    logic [CW-1:0]    r_fin_node;
    logic [DW-1:0]    r_top_min;
    logic [CW-1:0]    r_best;
    logic [DW-1:0]    r_score;

    logic             r_out_valid;
    t_out_item        r_out;

    logic [LW-1:0]    nl_used;
    logic [CW-1:0]    nn_used;
    logic             in_xfer;
    logic             out_free;
    logic             load;
    logic             issue;
    logic             last_lm;
    logic             last_node;
    logic             u_hi;
    logic             v_hi;
    logic             wr_ok;
    logic             we_fwd;
    logic             we_rev;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr_a;
    logic [AW-1:0]    raddr_b;
    logic [DW-1:0]    fwd_a;
    logic [DW-1:0]    fwd_b;
    logic [DW-1:0]    rev_a;
    logic [DW-1:0]    rev_b;
    logic [DW-1:0]    unit_out;
    t_unit_ctl        unit_ctl;

    assign nl_used = (32'(r_lm_count) > 32'(MAX_LANDMARKS)) ? LW'(MAX_LANDMARKS)
                                                           : LW'(r_lm_count);
    assign nn_used = (32'(r_node_count) > 32'(MAX_NODES)) ? CW'(MAX_NODES)
                                                          : CW'(r_node_count);

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign load      = (r_state == S_DRAIN) && !r_p_valid && !r_fin_valid && out_free;
    assign issue     = (r_state == S_ISSUE);
    assign last_lm   = (r_lm == nl_used - LW'(1));
    assign last_node = (r_node == nn_used - CW'(1));
    assign u_hi      = (32'(r_u) >= 32'(MAX_NODES));
    assign v_hi      = (32'(r_v) >= 32'(MAX_NODES));

    // table writes
    assign wr_ok  = (32'(i_in_data.landmark_index) < 32'(MAX_LANDMARKS))
                 && (32'(i_in_data.node_a) < 32'(MAX_NODES));
    assign we_fwd = in_xfer && wr_ok && (i_in_data.opcode == OP_WR_FWD);
    assign we_rev = in_xfer && wr_ok && (i_in_data.opcode == OP_WR_REV);
    assign waddr  = AW'(AW'(i_in_data.landmark_index) * AW'(MAX_NODES))
                  + AW'(i_in_data.node_a);

    always_comb begin
        if (r_kind == RK_FAR) begin
            raddr_a = r_base + AW'(r_node);
        end else begin
            raddr_a = r_base + AW'(r_u);
        end
        raddr_b = r_base + AW'(r_v);
    end

    llb_ram #(.WIDTH(DW), .DEPTH(DEPTH), .AW(AW)) u_fwd_ram (
        .i_clk     (i_clk),
        .i_we      (we_fwd),
        .i_waddr   (waddr),
        .i_wdata   (DW'(i_in_data.distance)),
        .i_raddr_a (raddr_a),
        .o_rdata_a (fwd_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (fwd_b)
    );

    llb_ram #(.WIDTH(DW), .DEPTH(DEPTH), .AW(AW)) u_rev_ram (
        .i_clk     (i_clk),
        .i_we      (we_rev),
        .i_waddr   (waddr),
        .i_wdata   (DW'(i_in_data.distance)),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rev_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rev_b)
    );

    assign unit_ctl.mode  = (r_kind == RK_FAR) ? UNIT_MIN : UNIT_MAX_DIFF;
    assign unit_ctl.first = r_p_first;

    llb_unit #(.DW(DW)) u_unit (
        .i_ctl   (unit_ctl),
        .i_fwd_a (fwd_a),
        .i_fwd_b (fwd_b),
        .i_rev_a (rev_a),
        .i_rev_b (rev_b),
        .i_acc   (r_acc),
        .o_acc   (unit_out)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_in_data.opcode == OP_BOUND)) begin
                    n_state = S_WRAP;
                end else if (in_xfer && (i_in_data.opcode == OP_FARTHEST)) begin
                    n_state = (nl_used == '0 || nn_used == '0) ? S_DRAIN : S_ISSUE;
                end
            end
            S_WRAP: begin
                if (!u_hi && !v_hi) begin
                    n_state = (nl_used == '0) ? S_DRAIN : S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (last_lm && (r_kind == RK_BOUND || last_node)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_lm_count   <= '0;
            r_node_count <= NDC_W'(1024);
            r_p_valid    <= 1'b0;
            r_fin_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p_valid   <= issue;
            r_fin_valid <= r_p_valid && r_p_last && (r_kind == RK_FAR);
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LANDMARK_COUNT) begin
                    r_lm_count <= i_cfg_data[LMC_W-1:0];
                end else begin
                    r_node_count <= i_cfg_data[NDC_W-1:0];
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind     <= (i_in_data.opcode == OP_FARTHEST) ? RK_FAR : RK_BOUND;
            r_u        <= i_in_data.node_a;
            r_v        <= i_in_data.node_b;
            r_lm       <= '0;
            r_node     <= '0;
            r_base     <= '0;
            r_acc      <= '0;
            r_best     <= '0;
            r_top_min  <= '0;
            r_score    <= '0;
        end
        if (r_state == S_WRAP) begin
            if (u_hi) begin
                r_u <= r_u - NODE_W'(MAX_NODES);
            end
            if (v_hi) begin
                r_v <= r_v - NODE_W'(MAX_NODES);
            end
        end
        if (issue) begin
            r_p_first <= (r_lm == '0);
            r_p_last  <= last_lm;
            r_p_node  <= r_node;
            if (last_lm) begin
                r_lm   <= '0;
                r_base <= '0;
                r_node <= r_node + CW'(1);
            end else begin
                r_lm   <= r_lm + LW'(1);
                r_base <= r_base + AW'(MAX_NODES);
            end
        end
        if (r_p_valid) begin
            r_acc <= unit_out;
            if (r_p_last) begin
                r_fin_m    <= unit_out;
                r_fin_node <= r_p_node;
            end
        end
        if (r_fin_valid) begin
            if (r_fin_m > r_top_min) begin
                r_top_min  <= r_fin_m;
                r_best     <= r_fin_node;
            end
            if (r_fin_m != '1 && r_fin_m > r_score) begin
                r_score <= r_fin_m;
            end
        end
        if (load) begin
            r_out.result_kind <= r_kind;
            if (r_kind == RK_FAR) begin
                r_out.bound          <= '0;
                r_out.farthest_node  <= NODE_W'(r_best);
                r_out.coverage_score <= VAL_W'(r_score);
            end else begin
                r_out.bound          <= VAL_W'(r_acc);
                r_out.farthest_node  <= '0;
                r_out.coverage_score <= '0;
            end
        end
    end

    `LLB_ASSERT_IMP(a_load_after_drain, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DRAIN, "result loaded outside drain")
    `LLB_ASSERT_IMP(a_tag_from_issue, i_clk, i_rst_n, r_p_valid, $past(r_state) == S_ISSUE, "read tag without issue")
    `LLB_ASSERT_IMP(a_lm_in_range, i_clk, i_rst_n, r_state == S_ISSUE, r_lm < nl_used, "landmark counter past count")
    `LLB_ASSERT_NXT(a_node_finish, i_clk, i_rst_n, r_p_valid && r_p_last && r_kind == RK_FAR, r_fin_valid, "node minimum not finished")

endmodule

// File: sv/llb_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module llb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: sv/llb_unit.sv
// Shared compare/subtract unit: max positive difference or running minimum.
// Depends on llb_pkg.
module llb_unit import llb_pkg::*; #(
    parameter int DW = 32
) (
    input  t_unit_ctl       i_ctl,
    input  logic [DW-1:0]   i_fwd_a,
    input  logic [DW-1:0]   i_fwd_b,
    input  logic [DW-1:0]   i_rev_a,
    input  logic [DW-1:0]   i_rev_b,
    input  logic [DW-1:0]   i_acc,
    output logic [DW-1:0]   o_acc
);

    logic [DW:0]   f_diff;
    logic [DW:0]   rev_diff;
    logic [DW-1:0] f_pos;
    logic [DW-1:0] rev_pos;
    logic [DW-1:0] cand;
    logic [DW-1:0] low;
    logic [DW-1:0] seed;

    always_comb begin
        // forward(v) - forward(u), reverse(u) - reverse(v); port a is u, b is v
        f_diff   = {1'b0, i_fwd_b} - {1'b0, i_fwd_a};
        rev_diff = {1'b0, i_rev_a} - {1'b0, i_rev_b};
        f_pos    = f_diff[DW] ? '0 : f_diff[DW-1:0];
        rev_pos  = rev_diff[DW] ? '0 : rev_diff[DW-1:0];
        cand     = (f_pos > rev_pos) ? f_pos : rev_pos;
        low      = (i_fwd_a < i_rev_a) ? i_fwd_a : i_rev_a;
        seed     = i_ctl.first ? '1 : i_acc;
        if (i_ctl.mode == UNIT_MIN) begin
            o_acc = (low < seed) ? low : seed;
        end else begin
            o_acc = (cand > i_acc) ? cand : i_acc;
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for landmark_lower_bound_engine: table writes, bound and farthest queries,
// checked transfer by transfer against a predictor held in a small scoreboard class.
// Depends on llb_pkg and the landmark_lower_bound_engine RTL.
module tb;
    import llb_pkg::*;

    localparam int LM_SLOTS     = 16;
    localparam int NODE_SLOTS   = 1024;
    localparam int HALF_PERIOD  = 5;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 930;
    localparam logic [VAL_W-1:0] UNREACHABLE = '1;

    class landmark_scoreboard;
        bit [VAL_W-1:0] fwd_dist [LM_SLOTS][NODE_SLOTS];
        bit [VAL_W-1:0] rev_dist [LM_SLOTS][NODE_SLOTS];
        logic [LMC_W-1:0] lm_count;
        logic [NDC_W-1:0] nd_count;
        t_out_item        answer_q[$];
        int errors, n_writes, n_bound, n_far, n_checked;

        function new();
            lm_count  = '0;
            nd_count  = NDC_W'(1024);
            errors    = 0;
            n_writes  = 0;
            n_bound   = 0;
            n_far     = 0;
            n_checked = 0;
        endfunction

        function int pending();
            return answer_q.size();
        endfunction

        function void set_cfg(logic idx, logic [CFG_W-1:0] val);
            if (idx == CFG_LANDMARK_COUNT)
                lm_count = val[LMC_W-1:0];
            else
                nd_count = val[NDC_W-1:0];
        endfunction

        function void note_item(t_in_item it);
            t_out_item res;
            int ul, un, u, v;
            logic [VAL_W-1:0] fu, fv, ru, rv, m, top_min;
            ul  = (lm_count > LM_SLOTS) ? LM_SLOTS : int'(lm_count);
            un  = (nd_count > NODE_SLOTS) ? NODE_SLOTS : int'(nd_count);
            res = '0;
            case (it.opcode)
                OP_WR_FWD: begin
                    fwd_dist[it.landmark_index][it.node_a] = it.distance;
                    n_writes++;
                end
                OP_WR_REV: begin
                    rev_dist[it.landmark_index][it.node_a] = it.distance;
                    n_writes++;
                end
                OP_BOUND: begin
                    u = int'(it.node_a) % NODE_SLOTS;
                    v = int'(it.node_b) % NODE_SLOTS;
                    res.result_kind = RK_BOUND;
                    for (int l = 0; l < ul; l++) begin
                        fu = fwd_dist[l][u];
                        fv = fwd_dist[l][v];
                        ru = rev_dist[l][u];
                        rv = rev_dist[l][v];
                        if (fv > fu && fv - fu > res.bound)
                            res.bound = fv - fu;
                        if (ru > rv && ru - rv > res.bound)
                            res.bound = ru - rv;
                    end
                    answer_q = {answer_q, res};
                    n_bound++;
                end
                default: begin
                    res.result_kind = RK_FAR;
                    top_min = '0;
                    for (int n = 0; n < un; n++) begin
                        m = UNREACHABLE;
                        for (int l = 0; l < ul; l++) begin
                            if (fwd_dist[l][n] < m)
                                m = fwd_dist[l][n];
                            if (rev_dist[l][n] < m)
                                m = rev_dist[l][n];
                        end
                        if (m > top_min) begin
                            top_min = m;
                            res.farthest_node = NODE_W'(n);
                        end
                        if (m != UNREACHABLE && m > res.coverage_score)
                            res.coverage_score = m;
                    end
                    answer_q = {answer_q, res};
                    n_far++;
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (answer_q.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", got));
                return;
            end
            want = answer_q.pop_front();
            n_checked++;
            if (got.result_kind !== want.result_kind)
                report_mismatch($sformatf("result_kind got %b want %b",
                                          got.result_kind, want.result_kind));
            if (got.bound !== want.bound)
                report_mismatch($sformatf("bound got %h want %h", got.bound, want.bound));
            if (got.farthest_node !== want.farthest_node)
                report_mismatch($sformatf("farthest_node got %0d want %0d",
                                          got.farthest_node, want.farthest_node));
            if (got.coverage_score !== want.coverage_score)
                report_mismatch($sformatf("coverage_score got %h want %h",
                                          got.coverage_score, want.coverage_score));
        endtask

        task flush_leftovers();
            t_out_item want;
            while (answer_q.size() > 0) begin
                want = answer_q.pop_front();
                report_mismatch($sformatf("expected result %h never arrived", want));
            end
        endtask
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_we    = 1'b0;
    logic             i_cfg_index = CFG_LANDMARK_COUNT;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    landmark_scoreboard sb;
    bit calm = 1'b0;
    bit fwd_seen [LM_SLOTS][NODE_SLOTS];
    bit rev_seen [LM_SLOTS][NODE_SLOTS];
    int used_lm, used_nd, n_settings;
    int region_q[$];
    int known_q[$];

    landmark_lower_bound_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall = !calm && ($urandom_range(99) < 27);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("** landmark_lower_bound_engine: FAILED **");
        $finish;
    end

    function automatic logic [VAL_W-1:0] rand_distance();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return UNREACHABLE;
        if (r < 50)
            return VAL_W'($urandom_range(15));
        if (r < 60)
            return UNREACHABLE - VAL_W'($urandom_range(15));
        return VAL_W'($urandom);
    endfunction

    function automatic t_in_item random_fields();
        t_in_item it;
        it.opcode         = 2'($urandom_range(3));
        it.landmark_index = 4'($urandom_range(15));
        it.node_a         = NODE_W'($urandom_range(NODE_SLOTS - 1));
        it.node_b         = NODE_W'($urandom_range(NODE_SLOTS - 1));
        it.distance       = rand_distance();
        return it;
    endfunction

    function automatic t_in_item mk_write(logic [1:0] op, int lmi, int node,
                                          logic [VAL_W-1:0] wr_dist);
        t_in_item it;
        it                = random_fields();
        it.opcode         = op;
        it.landmark_index = 4'(lmi);
        it.node_a         = NODE_W'(node);
        it.distance       = wr_dist;
        return it;
    endfunction

    function automatic t_in_item mk_query(logic [1:0] op, int u, int v);
        t_in_item it;
        it        = random_fields();
        it.opcode = op;
        it.node_a = NODE_W'(u);
        it.node_b = NODE_W'(v);
        return it;
    endfunction

    function automatic bit node_ready(int n);
        for (int l = 0; l < used_lm; l++)
            if (!fwd_seen[l][n] || !rev_seen[l][n])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit farthest_ready();
        for (int n = 0; n < used_nd; n++)
            if (!node_ready(n))
                return 1'b0;
        return 1'b1;
    endfunction

    // fills the region one node at a time so queries open up early
    function automatic bit find_gap(inout t_in_item it);
        foreach (region_q[i]) begin
            for (int l = 0; l < used_lm; l++) begin
                if (!fwd_seen[l][region_q[i]] || !rev_seen[l][region_q[i]]) begin
                    it.opcode = fwd_seen[l][region_q[i]] ? OP_WR_REV : OP_WR_FWD;
                    it.landmark_index = 4'(l);
                    it.node_a = NODE_W'(region_q[i]);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_in_item next_item();
        t_in_item it;
        int r;
        int ready_q[$];
        it = random_fields();
        r  = $urandom_range(99);
        if (r < 45) begin
            if ($urandom_range(99) < 70 && find_gap(it))
                return it;
            it.opcode = $urandom_range(1) ? OP_WR_FWD : OP_WR_REV;
            if ($urandom_range(1))
                it.node_a = NODE_W'(region_q[$urandom_range(region_q.size() - 1)]);
            return it;
        end
        if (r < 80) begin
            it.opcode = OP_BOUND;
            if (used_lm == 0)
                return it;
            foreach (known_q[i])
                if (node_ready(known_q[i]))
                    ready_q = {ready_q, known_q[i]};
            if (ready_q.size() > 0) begin
                it.node_a = NODE_W'(ready_q[$urandom_range(ready_q.size() - 1)]);
                it.node_b = NODE_W'(ready_q[$urandom_range(ready_q.size() - 1)]);
                return it;
            end
        end else if (farthest_ready()) begin
            it.opcode = OP_FARTHEST;
            return it;
        end
        if (!find_gap(it))
            it.opcode = OP_WR_FWD;
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(t_in_item it);
        if (it.opcode == OP_WR_FWD)
            fwd_seen[it.landmark_index][it.node_a] = 1'b1;
        else if (it.opcode == OP_WR_REV)
            rev_seen[it.landmark_index][it.node_a] = 1'b1;
        while (!calm && $urandom_range(99) < 27) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, int val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_W'(val);
        @(posedge i_clk);
        sb.set_cfg(idx, CFG_W'(val));
        n_settings++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic start_phase();
        int r, hot;
        bit known;
        r = $urandom_range(99);
        if (r < 10)
            used_lm = 0;
        else if (r < 70)
            used_lm = $urandom_range(1, 4);
        else if (r < 85)
            used_lm = $urandom_range(5, 15);
        else if (r < 95)
            used_lm = 16;
        else
            used_lm = $urandom_range(17, 31);
        r = $urandom_range(99);
        if (used_lm == 0)
            used_nd = (r < 40) ? $urandom_range(0, 2047) : (r < 70 ? 1024 : $urandom_range(16));
        else if (r < 5)
            used_nd = 0;
        else
            used_nd = $urandom_range(1, used_lm >= 16 ? 4 : (used_lm > 4 ? 6 : 12));
        write_cfg(CFG_LANDMARK_COUNT, used_lm);
        write_cfg(CFG_NODE_COUNT, used_nd);
        if (used_lm > LM_SLOTS)
            used_lm = LM_SLOTS;
        if (used_nd > NODE_SLOTS)
            used_nd = NODE_SLOTS;
        region_q.delete();
        if (used_lm > 0)
            for (int n = 0; n < used_nd; n++)
                region_q = {region_q, n};
        hot = $urandom_range(NODE_SLOTS - 1);
        region_q = {region_q, hot};
        foreach (region_q[i]) begin
            known = 1'b0;
            foreach (known_q[j])
                if (known_q[j] == region_q[i])
                    known = 1'b1;
            if (!known)
                known_q = {known_q, region_q[i]};
        end
    endtask

    initial begin
        int done, phase_len;
        sb         = new();
        done       = 0;
        n_settings = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: no landmarks, all nodes
        send_item(mk_query(OP_FARTHEST, 0, 0));
        send_item(mk_query(OP_BOUND, NODE_SLOTS - 1, 0));
        wait_drain();
        write_cfg(CFG_NODE_COUNT, 0);
        send_item(mk_query(OP_FARTHEST, 0, 0));
        wait_drain();
        write_cfg(CFG_NODE_COUNT, 2047);
        send_item(mk_query(OP_FARTHEST, 0, 0));
        send_item(mk_write(OP_WR_FWD, LM_SLOTS - 1, NODE_SLOTS - 1, UNREACHABLE));
        send_item(mk_write(OP_WR_REV, LM_SLOTS - 1, NODE_SLOTS - 1, '0));
        wait_drain();
        write_cfg(CFG_LANDMARK_COUNT, 1);
        write_cfg(CFG_NODE_COUNT, 2);
        send_item(mk_write(OP_WR_FWD, 0, 0, '0));
        send_item(mk_write(OP_WR_FWD, 0, 1, UNREACHABLE));
        send_item(mk_write(OP_WR_REV, 0, 0, UNREACHABLE));
        send_item(mk_write(OP_WR_REV, 0, 1, VAL_W'(5)));
        send_item(mk_query(OP_BOUND, 0, 1));
        send_item(mk_query(OP_BOUND, 1, 0));
        send_item(mk_query(OP_BOUND, 0, 0));
        send_item(mk_query(OP_FARTHEST, 0, 0));
        // node 1 becomes unreachable from every landmark
        send_item(mk_write(OP_WR_REV, 0, 1, UNREACHABLE));
        send_item(mk_query(OP_FARTHEST, 0, 0));
        wait_drain();
        write_cfg(CFG_LANDMARK_COUNT, 31);
        write_cfg(CFG_NODE_COUNT, 0);
        send_item(mk_query(OP_FARTHEST, 0, 0));

        while (done < RANDOM_ITEMS) begin
            wait_drain();
            start_phase();
            phase_len = $urandom_range(40, 110);
            for (int k = 0; k < phase_len && done < RANDOM_ITEMS; k++) begin
                calm = (done >= 350 && done < 500);
                if ($urandom_range(99) < 2)
                    wait_drain();
                send_item(next_item());
                done++;
            end
        end
        calm       = 1'b0;
        i_in_valid = 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.flush_leftovers();
        $display("Covered %0d table writes, %0d bound and %0d farthest queries",
                 sb.n_writes, sb.n_bound, sb.n_far);
        $display("across %0d register writes; %0d results checked, %0d mismatches.",
                 n_settings, sb.n_checked, sb.errors);
        if (sb.errors == 0)
            $display("** landmark_lower_bound_engine: PASSED **");
        else
            $display("** landmark_lower_bound_engine: FAILED **");
        $finish;
    end
endmodule
